### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the socket table block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### src/udpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP socket table package
// Shared constants, operation and status codes.
// ----------------------------------------------------------------------------
package udpst_pkg;
  localparam int NUM_SOCKETS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_PAYLOAD_DEF = 1472;
  localparam logic [15:0] EPH_BASE_RST = 16'd49152;
  localparam logic [15:0] PORT_TOP = 16'd65535;
  localparam logic [15:0] HDR_LEN = 16'd8;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_BIND = 3'd1;
  localparam logic [2:0] OP_CONNECT = 3'd2;
  localparam logic [2:0] OP_CLOSE = 3'd3;
  localparam logic [2:0] OP_DELIVER = 3'd4;
  localparam logic [2:0] OP_RECEIVE = 3'd5;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_BOUND = 2'd1;
  localparam logic [1:0] MODE_CONNECTED = 2'd2;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_NO_SOCKET = 4'd1;
  localparam logic [3:0] ST_BAD_SOCKET = 4'd2;
  localparam logic [3:0] ST_PORT_USED = 4'd3;
  localparam logic [3:0] ST_NO_PORT = 4'd4;
  localparam logic [3:0] ST_MALFORMED = 4'd5;
  localparam logic [3:0] ST_NO_LISTENER = 4'd6;
  localparam logic [3:0] ST_QUEUE_FULL = 4'd7;
  localparam logic [3:0] ST_QUEUE_EMPTY = 4'd8;

  // Queued datagram descriptor.
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [10:0] len;
  } rx_desc_t;
endpackage

### src/udpst_queue_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive queue memory
// One write and one registered read port for all socket queues.
// ----------------------------------------------------------------------------
module udpst_queue_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  udpst_pkg::rx_desc_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output udpst_pkg::rx_desc_t rd_data
);
  import udpst_pkg::*;

  rx_desc_t mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### src/udp_port_demux_socket_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP socket table with port demultiplexing
// Socket slots, ephemeral port allocation, demux and receive queues.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in_*    | input     | in_valid / in_ready, one operation
//  out_*   | output    | out_valid / out_ready, one result
//  cfg_*   | input     | cfg_valid / cfg_ready, ephemeral base
// Create, bind, deliver and ephemeral allocation scan the socket table one
// slot per cycle with one shared compare unit. Close, connect of a bound slot
// and a malformed deliver finish without a scan, receive reads the queue
// memory through S_RD and S_RDW, and ephemeral bind or connect makes a full
// pass per candidate port. Reset is synchronous and clears all slots.
// in_ready and cfg_ready are low from acceptance until the result is taken,
// and in_ready is also low while cfg_valid is high.
module udp_port_demux_socket_table #(
  parameter int NUM_SOCKETS = udpst_pkg::NUM_SOCKETS_DEF,
  parameter int QUEUE_DEPTH = udpst_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD = udpst_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_socket_index,
  input  logic [15:0] in_local_port,
  input  logic [31:0] in_peer_ip,
  input  logic [15:0] in_peer_port,
  input  logic [15:0] in_dst_port,
  input  logic [15:0] in_udp_length,
  input  logic [15:0] in_packet_length,
  input  logic [15:0] in_max_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [2:0]  out_socket_out,
  output logic [15:0] out_bound_port,
  output logic [31:0] out_rx_peer_ip,
  output logic [15:0] out_rx_peer_port,
  output logic [10:0] out_rx_length,
  output logic [31:0] out_total_received,
  output logic [31:0] out_malformed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import udpst_pkg::*;
  `include "assert_macros.svh"

  localparam int SW = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(NUM_SOCKETS + 2);
  localparam int MW = SW + QW;
  localparam logic [15:0] MAXP = 16'(MAX_PAYLOAD);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_RD = 3'd3;
  localparam logic [2:0] S_RDW = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [1:0]    mode_r [NUM_SOCKETS];
  logic [15:0]   lport_r [NUM_SOCKETS];
  logic [31:0]   rip_r [NUM_SOCKETS];
  logic [15:0]   rport_r [NUM_SOCKETS];
  logic [QW-1:0] head_r [NUM_SOCKETS];
  logic [QW-1:0] tail_r [NUM_SOCKETS];
  logic [CW-1:0] cnt_r [NUM_SOCKETS];

  logic [15:0] eph_base_r, next_eph_r, cand_r, start_r;
  logic [31:0] recv_r, err_r;
  logic [2:0]  op_r;
  logic [SW-1:0] sidx_r, scan_r;
  logic        sval_r;
  logic [15:0] lp_r, pport_r, dport_r, ulen_r, maxl_r;
  logic [31:0] pip_r;
  logic [NW-1:0] tries_r;
  logic        taken_r;
  logic [3:0]  st_r;
  logic [2:0]  sout_r;
  logic [15:0] bport_r;
  rx_desc_t    rd_desc;
  logic        wr_en;
  logic [MW-1:0] wr_addr, rd_addr;
  rx_desc_t    wr_desc;
  logic [15:0] dl;

  assign in_ready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  // Shared compare unit: one slot per cycle.
  logic [1:0]  m_s;
  logic [15:0] p_s;
  logic        hit_port, hit_peer;
  assign m_s = mode_r[scan_r];
  assign p_s = lport_r[scan_r];
  assign hit_port = (m_s != MODE_CLOSED) && (p_s == ((op_r == OP_DELIVER) ? dport_r :
                    (state_r == S_ALLOC) ? cand_r : lp_r));
  assign hit_peer = (m_s != MODE_CONNECTED) ||
                    (rip_r[scan_r] == pip_r && rport_r[scan_r] == pport_r);
  logic last_slot;
  assign last_slot = (32'(scan_r) == NUM_SOCKETS - 1);
  logic [15:0] cand_step;
  assign cand_step = (cand_r == PORT_TOP) ? eph_base_r : cand_r + 16'd1;

  assign dl = (ulen_r - HDR_LEN > MAXP) ? MAXP : ulen_r - HDR_LEN;
  assign wr_desc = '{ip: pip_r, port: pport_r, len: dl[10:0]};
  assign rd_addr = {sidx_r, head_r[sidx_r]};

  udpst_queue_mem #(.DEPTH(2 ** MW), .AW(MW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_desc),
    .rd_addr(rd_addr), .rd_data(rd_desc)
  );

  // Queue write strobe for a datagram that found room in its queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en <= 1'b0;
    end else begin
      wr_en <= (state_r == S_SCAN) && (op_r == OP_DELIVER) && hit_port && hit_peer &&
               (32'(cnt_r[scan_r]) < QUEUE_DEPTH);
    end
  end

  // Sequencer and state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      eph_base_r <= EPH_BASE_RST;
      next_eph_r <= EPH_BASE_RST;
      recv_r <= '0;
      err_r <= '0;
      for (int i = 0; i < NUM_SOCKETS; i++) begin
        mode_r[i] <= MODE_CLOSED;
        lport_r[i] <= '0;
        rip_r[i] <= '0;
        rport_r[i] <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            eph_base_r <= cfg_data;
          end else if (in_valid) begin
            op_r <= in_op;
            sidx_r <= SW'(in_socket_index);
            sval_r <= (32'(in_socket_index) < NUM_SOCKETS);
            lp_r <= in_local_port;
            pip_r <= in_peer_ip;
            pport_r <= in_peer_port;
            dport_r <= in_dst_port;
            ulen_r <= in_udp_length;
            maxl_r <= in_max_length;
            scan_r <= '0;
            taken_r <= 1'b0;
            sout_r <= '0;
            bport_r <= '0;
            if (in_op == OP_DELIVER && (in_packet_length < HDR_LEN ||
                in_udp_length < HDR_LEN || in_udp_length > in_packet_length)) begin
              err_r <= err_r + 32'd1;
              st_r <= ST_MALFORMED;
              state_r <= S_DONE;
            end else if (in_op == OP_DELIVER) begin
              recv_r <= recv_r + 32'd1;
              st_r <= ST_NO_LISTENER;
              state_r <= S_SCAN;
            end else begin
              st_r <= ST_OK;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          case (op_r)
            OP_CREATE: begin
              if (m_s == MODE_CLOSED) begin
                mode_r[scan_r] <= MODE_BOUND;
                lport_r[scan_r] <= '0;
                rip_r[scan_r] <= '0;
                rport_r[scan_r] <= '0;
                head_r[scan_r] <= '0;
                tail_r[scan_r] <= '0;
                cnt_r[scan_r] <= '0;
                sout_r <= 3'(scan_r);
                state_r <= S_DONE;
              end else if (last_slot) begin
                st_r <= ST_NO_SOCKET;
                state_r <= S_DONE;
              end else begin
                scan_r <= scan_r + 1'b1;
              end
            end
            OP_BIND, OP_CONNECT: begin
              if (!sval_r || mode_r[sidx_r] == MODE_CLOSED) begin
                st_r <= ST_BAD_SOCKET;
                state_r <= S_DONE;
              end else if (op_r == OP_CONNECT && lport_r[sidx_r] != 16'd0) begin
                mode_r[sidx_r] <= MODE_CONNECTED;
                rip_r[sidx_r] <= pip_r;
                rport_r[sidx_r] <= pport_r;
                bport_r <= lport_r[sidx_r];
                state_r <= S_DONE;
              end else if (op_r == OP_CONNECT || lp_r == 16'd0) begin
                cand_r <= next_eph_r;
                start_r <= next_eph_r;
                tries_r <= '0;
                scan_r <= '0;
                taken_r <= 1'b0;
                state_r <= S_ALLOC;
              end else if (hit_port) begin
                st_r <= ST_PORT_USED;
                state_r <= S_DONE;
              end else if (last_slot) begin
                lport_r[sidx_r] <= lp_r;
                mode_r[sidx_r] <= MODE_BOUND;
                bport_r <= lp_r;
                state_r <= S_DONE;
              end else begin
                scan_r <= scan_r + 1'b1;
              end
            end
            OP_CLOSE: begin
              if (!sval_r) begin
                st_r <= ST_BAD_SOCKET;
              end else begin
                mode_r[sidx_r] <= MODE_CLOSED;
                lport_r[sidx_r] <= '0;
                rip_r[sidx_r] <= '0;
                rport_r[sidx_r] <= '0;
                head_r[sidx_r] <= '0;
                tail_r[sidx_r] <= '0;
                cnt_r[sidx_r] <= '0;
              end
              state_r <= S_DONE;
            end
            OP_DELIVER: begin
              if (hit_port && hit_peer) begin
                if (32'(cnt_r[scan_r]) < QUEUE_DEPTH) begin
                  wr_addr <= {scan_r, tail_r[scan_r]};
                  tail_r[scan_r] <= (32'(tail_r[scan_r]) == QUEUE_DEPTH - 1) ? '0 :
                                    tail_r[scan_r] + 1'b1;
                  cnt_r[scan_r] <= cnt_r[scan_r] + 1'b1;
                  st_r <= ST_OK;
                end else begin
                  st_r <= ST_QUEUE_FULL;
                end
                state_r <= S_DONE;
              end else if (last_slot) begin
                state_r <= S_DONE;
              end else begin
                scan_r <= scan_r + 1'b1;
              end
            end
            OP_RECEIVE: begin
              if (!sval_r || mode_r[sidx_r] == MODE_CLOSED) begin
                st_r <= ST_BAD_SOCKET;
                state_r <= S_DONE;
              end else if (cnt_r[sidx_r] == '0) begin
                st_r <= ST_QUEUE_EMPTY;
                state_r <= S_DONE;
              end else begin
                state_r <= S_RD;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_ALLOC: begin
          // Check one slot against the current candidate.
          if (last_slot) begin
            scan_r <= '0;
            taken_r <= 1'b0;
            if (cand_r != 16'd0 && !hit_port && !taken_r) begin
              next_eph_r <= cand_step;
              lport_r[sidx_r] <= cand_r;
              bport_r <= cand_r;
              if (op_r == OP_CONNECT) begin
                mode_r[sidx_r] <= MODE_CONNECTED;
                rip_r[sidx_r] <= pip_r;
                rport_r[sidx_r] <= pport_r;
              end else begin
                mode_r[sidx_r] <= MODE_BOUND;
              end
              state_r <= S_DONE;
            end else if (32'(tries_r) == NUM_SOCKETS || cand_step == start_r) begin
              st_r <= ST_NO_PORT;
              state_r <= S_DONE;
            end else begin
              cand_r <= cand_step;
              tries_r <= tries_r + 1'b1;
            end
          end else begin
            if (hit_port) begin
              taken_r <= 1'b1;
            end
            scan_r <= scan_r + 1'b1;
          end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          pip_r <= rd_desc.ip;
          pport_r <= rd_desc.port;
          bport_r <= (16'(rd_desc.len) < maxl_r) ? 16'(rd_desc.len) : maxl_r;
          head_r[sidx_r] <= (32'(head_r[sidx_r]) == QUEUE_DEPTH - 1) ? '0 :
                            head_r[sidx_r] + 1'b1;
          cnt_r[sidx_r] <= cnt_r[sidx_r] - 1'b1;
          op_r <= OP_RECEIVE;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result formatting.
  logic is_rx;
  assign is_rx = (op_r == OP_RECEIVE) && (st_r == ST_OK);
  assign out_status = st_r;
  assign out_socket_out = sout_r;
  assign out_bound_port = (op_r == OP_BIND || op_r == OP_CONNECT) ? bport_r : 16'd0;
  assign out_rx_peer_ip = is_rx ? pip_r : 32'd0;
  assign out_rx_peer_port = is_rx ? pport_r : 16'd0;
  assign out_rx_length = is_rx ? bport_r[10:0] : 11'd0;
  assign out_total_received = recv_r;
  assign out_malformed_count = err_r;

  `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLIES(a_status_rng, clk, rst_n, out_valid, out_status <= ST_QUEUE_EMPTY)
endmodule
